@@ hdl/cbp_pkg.sv @@
// Shared types, sizes and index function of the correlating branch predictor.
package cbp_pkg;

    localparam int HISTORY_BITS   = 10;
    localparam int PC_INDEX_BITS  = 2;
    localparam int INDEX_BITS     = HISTORY_BITS + PC_INDEX_BITS;
    localparam int TABLE_DEPTH    = 1 << INDEX_BITS;
    localparam int CTR_BITS       = 2;
    localparam int PC_BITS        = 32;
    localparam int PC_WORD_BITS   = PC_BITS - 2;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;

    localparam logic [CTR_BITS-1:0] CTR_MIN   = '0;
    localparam logic [CTR_BITS-1:0] CTR_MAX   = '1;
    localparam logic [CTR_BITS-1:0] CTR_TAKEN = CTR_BITS'(2);

    localparam logic [PC_WORD_BITS-1:0] PC_SEL_MASK =
        PC_WORD_BITS'((64'd1 << PC_INDEX_BITS) - 64'd1);

    typedef struct packed {
        logic [PC_BITS-1:0] branch_pc;
        logic               actual_taken;
    } branch_item_t;

    typedef struct packed {
        logic predicted_taken;
        logic prediction_correct;
    } result_item_t;

    typedef struct packed {
        logic                  en;
        logic [INDEX_BITS-1:0] addr;
        logic [CTR_BITS-1:0]   data;
    } ctr_write_t;

    function automatic logic [INDEX_BITS-1:0] table_index(
        input logic [HISTORY_BITS-1:0] history,
        input logic [PC_BITS-1:0]      pc
    );
        logic [HISTORY_BITS+PC_WORD_BITS-1:0] wide;
        wide = {history, {PC_WORD_BITS{1'b0}}} >> (PC_WORD_BITS - PC_INDEX_BITS);
        wide = wide | {{HISTORY_BITS{1'b0}}, pc[PC_BITS-1:2] & PC_SEL_MASK};
        return wide[INDEX_BITS-1:0];
    endfunction

endpackage

@@ hdl/cbp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module cbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/cbp_counter_stage.sv @@
// Read-modify-write stage: predicts from the counter, saturates it and writes it back.
module cbp_counter_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [cbp_pkg::INDEX_BITS-1:0] index,
    input  logic                          taken,
    input  logic [cbp_pkg::CTR_BITS-1:0]   rd_data,
    output cbp_pkg::ctr_write_t           wr,
    output logic                          res_valid,
    output cbp_pkg::result_item_t         res
);

    logic                           s1_valid_reg;
    logic [cbp_pkg::INDEX_BITS-1:0] s1_index_reg;
    logic                           s1_taken_reg;
    logic                           fwd_valid_reg;
    logic [cbp_pkg::INDEX_BITS-1:0] fwd_addr_reg;
    logic [cbp_pkg::CTR_BITS-1:0]   fwd_data_reg;
    logic [cbp_pkg::CTR_BITS-1:0]   ctr;
    logic [cbp_pkg::CTR_BITS-1:0]   ctr_next;
    logic                           pred;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept;
            fwd_valid_reg <= wr.en;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_index_reg <= index;
        s1_taken_reg <= taken;
        fwd_addr_reg <= wr.addr;
        fwd_data_reg <= wr.data;
    end

    // The RAM returns the old value when the previous item wrote the same entry.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_index_reg))
        begin
            ctr = fwd_data_reg;
        end
        else
        begin
            ctr = rd_data;
        end

        pred = (ctr >= cbp_pkg::CTR_TAKEN);

        if (s1_taken_reg)
        begin
            ctr_next = (ctr == cbp_pkg::CTR_MAX) ? ctr : ctr + cbp_pkg::CTR_BITS'(1);
        end
        else
        begin
            ctr_next = (ctr == cbp_pkg::CTR_MIN) ? ctr : ctr - cbp_pkg::CTR_BITS'(1);
        end
    end

    assign wr.en   = s1_valid_reg;
    assign wr.addr = s1_index_reg;
    assign wr.data = ctr_next;

    assign res_valid              = s1_valid_reg;
    assign res.predicted_taken    = pred;
    assign res.prediction_correct = (pred == s1_taken_reg);

endmodule

@@ hdl/cbp_out_queue.sv @@
// Small result queue that decouples the counter stage from the result channel.
module cbp_out_queue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  cbp_pkg::result_item_t             push_item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output cbp_pkg::result_item_t             result,
    output logic [cbp_pkg::QUEUE_CNT_BITS-1:0] count
);

    cbp_pkg::result_item_t               entry_reg [cbp_pkg::QUEUE_DEPTH];
    logic [cbp_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_reg;
    logic [cbp_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_reg;
    logic [cbp_pkg::QUEUE_CNT_BITS-1:0]  count_reg;
    logic [cbp_pkg::QUEUE_CNT_BITS-1:0]  count_next;
    logic                                pop;

    assign pop = result_valid && !result_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + cbp_pkg::QUEUE_CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - cbp_pkg::QUEUE_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + cbp_pkg::QUEUE_PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + cbp_pkg::QUEUE_PTR_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign result_valid = (count_reg != '0);
    assign result       = entry_reg[rd_ptr_reg];
    assign count        = count_reg;

endmodule

@@ hdl/correlating_branch_predictor.sv @@
// Top level of the gselect correlating branch predictor.
// Each item is one resolved branch; the block returns one result item per branch with the
// prediction made from the 2-bit counter before its update and whether it was right. After
// reset the block clears the 4096-entry counter RAM one entry per cycle, with branch_stall
// high until the clear is done. After that it takes one branch every cycle while the result
// queue has room: the counter is read from a single-ported-read RAM and written back by the
// counter stage in the following cycle, with the last write forwarded so back-to-back branches
// to the same entry see each other. Results pass from the counter stage through a four-entry
// queue, which keeps full rate as long as result_stall is low.
module correlating_branch_predictor (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  branch_valid,
    output logic                  branch_stall,
    input  cbp_pkg::branch_item_t branch,
    output logic                  result_valid,
    input  logic                  result_stall,
    output cbp_pkg::result_item_t result
);

    logic [cbp_pkg::HISTORY_BITS-1:0]   history_reg;
    logic [cbp_pkg::HISTORY_BITS-1:0]   history_next;
    logic                               clear_busy_reg;
    logic [cbp_pkg::INDEX_BITS-1:0]     clear_addr_reg;
    logic                               accept;
    logic [cbp_pkg::INDEX_BITS-1:0]     index;
    logic [cbp_pkg::CTR_BITS-1:0]       rd_data;
    cbp_pkg::ctr_write_t                stage_wr;
    cbp_pkg::ctr_write_t                ram_wr;
    logic                               res_valid;
    cbp_pkg::result_item_t              res;
    logic [cbp_pkg::QUEUE_CNT_BITS-1:0] queue_count;
    logic [cbp_pkg::QUEUE_CNT_BITS:0]   fill;

    assign fill = {1'b0, queue_count} + {{cbp_pkg::QUEUE_CNT_BITS{1'b0}}, res_valid};
    assign branch_stall = clear_busy_reg ||
                          (fill >= (cbp_pkg::QUEUE_CNT_BITS + 1)'(cbp_pkg::QUEUE_DEPTH));
    assign accept = branch_valid && !branch_stall;

    assign index        = cbp_pkg::table_index(history_reg, branch.branch_pc);
    assign history_next = cbp_pkg::HISTORY_BITS'({history_reg, branch.actual_taken});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg    <= '1;
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                history_reg <= history_next;
            end
            if (clear_busy_reg)
            begin
                clear_addr_reg <= clear_addr_reg + cbp_pkg::INDEX_BITS'(1);
                if (clear_addr_reg == '1)
                begin
                    clear_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        if (clear_busy_reg)
        begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = clear_addr_reg;
            ram_wr.data = cbp_pkg::CTR_MIN;
        end
        else
        begin
            ram_wr = stage_wr;
        end
    end

    cbp_ram #(
        .WIDTH (cbp_pkg::CTR_BITS),
        .DEPTH (cbp_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_addr (index),
        .rd_data (rd_data)
    );

    cbp_counter_stage u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .index     (index),
        .taken     (branch.actual_taken),
        .rd_data   (rd_data),
        .wr        (stage_wr),
        .res_valid (res_valid),
        .res       (res)
    );

    cbp_out_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (res_valid),
        .push_item    (res),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .count        (queue_count)
    );

    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) accept |-> !clear_busy_reg
    ) else $error("branch accepted during the table clear");

    a_writeback_follows_accept: assert property (
        @(posedge clk) disable iff (!rst_n) accept |=> stage_wr.en
    ) else $error("accepted branch did not write back its counter");

    a_queue_no_overflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        queue_count <= cbp_pkg::QUEUE_CNT_BITS'(cbp_pkg::QUEUE_DEPTH)
    ) else $error("result queue overflow");

    a_history_untouched_by_clear: assert property (
        @(posedge clk) disable iff (!rst_n) $fell(clear_busy_reg) |-> (history_reg == '1)
    ) else $error("history changed before the table clear finished");

endmodule

@@ test/branch_predict_checker.sv @@
`timescale 1ns / 1ps
// Checker that mirrors the gselect predictor and compares every result item in order.
module branch_predict_checker
    import cbp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         branch_valid,
    input  logic         branch_stall,
    input  branch_item_t branch,
    input  logic         result_valid,
    input  logic         result_stall,
    input  result_item_t result,
    output int           mismatches,
    output int           outstanding
);

    logic [HISTORY_BITS-1:0] history;
    logic [CTR_BITS-1:0]     counters [TABLE_DEPTH];
    result_item_t            awaited_results [$];
    result_item_t            predicted;
    result_item_t            oldest;
    int                      mismatch_count = 0;

    assign mismatches = mismatch_count;

    function automatic result_item_t resolve_branch(input branch_item_t b);
        logic [INDEX_BITS-1:0] idx;
        logic [CTR_BITS-1:0]   ctr;
        result_item_t          r;
        idx = {history, b.branch_pc[2 +: PC_INDEX_BITS]};
        ctr = counters[idx];
        r.predicted_taken    = (ctr >= CTR_TAKEN);
        r.prediction_correct = (r.predicted_taken == b.actual_taken);
        if (b.actual_taken && ctr != CTR_MAX)
        begin
            ctr = ctr + CTR_BITS'(1);
        end
        else if (!b.actual_taken && ctr != CTR_MIN)
        begin
            ctr = ctr - CTR_BITS'(1);
        end
        counters[idx] = ctr;
        history = {history[HISTORY_BITS-2:0], b.actual_taken};
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history = '1;
            foreach (counters[i])
            begin
                counters[i] = CTR_MIN;
            end
            awaited_results.delete();
        end
        else
        begin
            if (branch_valid && !branch_stall)
            begin
                predicted = resolve_branch(branch);
                awaited_results.insert(awaited_results.size(), predicted);
            end
            if (result_valid && !result_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result item with no branch waiting: predicted_taken %0b",
                           result.predicted_taken);
                    mismatch_count++;
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    if (result.predicted_taken !== oldest.predicted_taken)
                    begin
                        $error("predicted_taken: expected %0b, actual %0b",
                               oldest.predicted_taken, result.predicted_taken);
                        mismatch_count++;
                    end
                    if (result.prediction_correct !== oldest.prediction_correct)
                    begin
                        $error("prediction_correct: expected %0b, actual %0b",
                               oldest.prediction_correct, result.prediction_correct);
                        mismatch_count++;
                    end
                end
            end
        end
        outstanding = awaited_results.size();
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, branch stimulus, result stalls and the verdict.
module testbench;
    import cbp_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 200000;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         branch_valid = 1'b0;
    logic         branch_stall;
    branch_item_t branch       = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_item_t result;

    int           mismatches;
    int           outstanding;
    int           items_sent   = 0;
    int           cycle_count  = 0;
    logic         sender_gaps  = 1'b0;
    logic         receiver_gaps = 1'b0;
    logic         hold_results = 1'b0;
    logic [PC_BITS-1:0] loop_pcs [8];

    correlating_branch_predictor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .branch_valid (branch_valid),
        .branch_stall (branch_stall),
        .branch       (branch),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    branch_predict_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .branch_valid (branch_valid),
        .branch_stall (branch_stall),
        .branch       (branch),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // The receiver stalls in short random bursts, or for one long stretch on request.
    initial
    begin
        forever
        begin
            if (hold_results)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                result_stall <= 1'b0;
                hold_results = 1'b0;
                @(posedge clk);
            end
            else if (receiver_gaps && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                result_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                @(posedge clk);
            end
        end
    end

    task automatic send_branch(input logic [PC_BITS-1:0] pc, input logic taken);
        if (sender_gaps && $urandom_range(0, 7) == 0)
        begin
            branch_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        branch_valid <= 1'b1;
        branch       <= '{branch_pc: pc, actual_taken: taken};
        @(posedge clk);
        while (branch_stall) @(posedge clk);
        items_sent++;
    endtask

    // Mostly loop-shaped branch streams that train the counters, with some pure noise.
    task automatic send_branch_mix(input int target);
        logic [PC_BITS-1:0] pc;
        int                 kind;
        int                 trips;
        while (items_sent < target)
        begin
            kind = $urandom_range(0, 9);
            pc   = loop_pcs[$urandom_range(0, 7)];
            if (kind <= 6)
            begin
                trips = $urandom_range(1, 12);
                repeat (trips) send_branch(pc, 1'b1);
                send_branch(pc, 1'b0);
            end
            else if (kind == 7)
            begin
                repeat (8) send_branch(pc, $urandom_range(0, 3) != 0);
            end
            else
            begin
                repeat ($urandom_range(1, 4)) send_branch($urandom, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic drain_results;
        branch_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        foreach (loop_pcs[i])
        begin
            loop_pcs[i] = $urandom;
        end
        repeat (12) @(posedge clk);
        rst_n         <= 1'b1;
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;

        // History starts all ones, so repeated taken branches hit one counter up to saturation.
        repeat (5) send_branch(32'h0000_0008, 1'b1);
        // Twelve not-taken branches clear the history and then pin a counter at zero.
        repeat (12) send_branch(32'hFFFF_FFFF, 1'b0);
        send_branch(32'h0000_0000, 1'b1);
        send_branch(32'h0000_0003, 1'b1);
        send_branch(32'h0000_000C, 1'b0);
        send_branch(32'hFFFF_FFF0, 1'b1);
        send_branch(32'h8000_0004, 1'b0);
        send_branch(32'h7FFF_FFFB, 1'b1);

        send_branch_mix(520);
        hold_results = 1'b1;
        send_branch_mix(700);
        drain_results();
        send_branch_mix(1130);
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        send_branch_mix(1370);
        drain_results();

        if (mismatches == 0 && outstanding == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
